@@ hdl/text_console_cursor_engine_core_macros.svh @@
// Assertion macros for the text console cursor engine.
// Used by modules that have clk and rst_n ports; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define TCCE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCE_ASSERT_IMPL(label, ante, cons, msg)
`define TCCE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/tcce_pkg.sv @@
// Shared types, codes and constants of the text console cursor engine.
// No dependencies.
package tcce_pkg;

    // Screen limits and register defaults
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;
    localparam int COL_LIMIT = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int ROW_LIMIT = (MAX_ROWS < 128) ? MAX_ROWS : 128;

    localparam logic [8:0]  WIDTH_RESET  = 9'd80;
    localparam logic [7:0]  HEIGHT_RESET = 8'd25;
    localparam logic [31:0] FORE_RESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] BACK_RESET   = 32'hFF00_0000;

    // Queue depths
    localparam int ITEM_Q_DEPTH = 2;
    localparam int CMD_Q_DEPTH  = 2;

    // Configuration register indexes
    localparam logic [7:0] REG_WIDTH  = 8'd0;
    localparam logic [7:0] REG_HEIGHT = 8'd1;
    localparam logic [7:0] REG_FORE   = 8'd2;
    localparam logic [7:0] REG_BACK   = 8'd3;

    // Request types
    localparam logic REQ_CHAR  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Control bytes
    localparam logic [7:0] CHAR_BS  = 8'd8;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_NL  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // Tab stop arithmetic
    localparam logic [8:0] TAB_STEP = 9'd4;
    localparam logic [8:0] TAB_MASK = ~9'd3;

    // Item classes decided by the front end
    localparam logic [2:0] KIND_GLYPH = 3'd0;
    localparam logic [2:0] KIND_NL    = 3'd1;
    localparam logic [2:0] KIND_BS    = 3'd2;
    localparam logic [2:0] KIND_CR    = 3'd3;
    localparam logic [2:0] KIND_TAB   = 3'd4;
    localparam logic [2:0] KIND_CLEAR = 3'd5;

    // Cell command codes
    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] code;
    } item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] col;
        logic [6:0] row;
        logic [7:0] glyph;
        logic       last;
    } cmd_t;

    // Effective screen size, already clamped
    typedef struct packed {
        logic [8:0] w;
        logic [7:0] h;
    } geom_t;

endpackage

@@ hdl/text_console_cursor_engine_core.sv @@
// Text console cursor engine, top level: configuration registers and the stage chain.
// Depends on tcce_pkg, tcce_fifo, tcce_front and tcce_back.
//
// Use: write items (req_type, char_code) with push while full is low. Each item
// yields zero, one or two cell commands, read from the result side: a command
// is shown while empty is low and taken with pop. last_of_run marks the final
// command of an item; control bytes that cause nothing yield no command.
// Configuration writes go over cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high. Index 0 width, 1 height, 2 foreground, 3 background; others are ignored.
// A command is popped after passing the item queue, then the command queue.
// Throughput, while the command queue has room: one item per cycle when it yields
// at most one command; an item that draws or erases and also scrolls keeps the next
// item waiting until its scroll is pushed; the back end emits one command per cycle.
// Reset homes the cursor, empties both queues and loads 80x25 cells, white ink
// on black paper. When the result side stalls, the command queue fills, the back
// end holds, then the item queue fills and full rises.
module text_console_cursor_engine_core
    import tcce_pkg::*;
#(
    parameter int ITEM_DEPTH = ITEM_Q_DEPTH,
    parameter int CMD_DEPTH  = CMD_Q_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  char_code,
    // cell commands
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  cell_op,
    output logic [7:0]  cell_col,
    output logic [6:0]  cell_row,
    output logic [7:0]  glyph_code,
    output logic [31:0] ink_color,
    output logic [31:0] paper_color,
    output logic        last_of_run,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ITEM_W = $bits(item_t);
    localparam int CMD_W  = $bits(cmd_t);
    localparam logic [8:0] COL_MAX = 9'(COL_LIMIT);
    localparam logic [7:0] ROW_MAX = 8'(ROW_LIMIT);

    logic [8:0]  width_reg;
    logic [7:0]  height_reg;
    logic [31:0] fore_reg;
    logic [31:0] back_reg;
    geom_t       geom;

    logic              iq_push, iq_full, iq_empty, iq_pop;
    item_t             iq_in, iq_out;
    logic [ITEM_W-1:0] iq_out_bits;
    logic              cq_push, cq_full;
    cmd_t              cq_in, cq_out;
    logic [CMD_W-1:0]  cq_out_bits;

    assign cfg_ready = 1'b1;

    // Load configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            fore_reg   <= FORE_RESET;
            back_reg   <= BACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[8:0];
                REG_HEIGHT: height_reg <= cfg_data[7:0];
                REG_FORE:   fore_reg   <= cfg_data;
                REG_BACK:   back_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp screen size: zero acts as one, large values saturate
    always_comb
    begin
        geom.w = width_reg;
        if (width_reg == '0)
        begin
            geom.w = 9'd1;
        end
        else if (width_reg > COL_MAX)
        begin
            geom.w = COL_MAX;
        end
        geom.h = height_reg;
        if (height_reg == '0)
        begin
            geom.h = 8'd1;
        end
        else if (height_reg > ROW_MAX)
        begin
            geom.h = ROW_MAX;
        end
    end

    tcce_front u_front (
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .char_code (char_code),
        .q_push    (iq_push),
        .q_data    (iq_in),
        .q_full    (iq_full)
    );

    tcce_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (iq_push),
        .push_data (iq_in),
        .full      (iq_full),
        .pop       (iq_pop),
        .pop_data  (iq_out_bits),
        .empty     (iq_empty)
    );

    assign iq_out = iq_out_bits;

    tcce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .item_empty (iq_empty),
        .item_data  (iq_out),
        .item_pop   (iq_pop),
        .out_full   (cq_full),
        .cmd_push   (cq_push),
        .cmd_data   (cq_in)
    );

    tcce_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cq_push),
        .push_data (cq_in),
        .full      (cq_full),
        .pop       (pop),
        .pop_data  (cq_out_bits),
        .empty     (empty)
    );

    // Drive outputs; user keeps colors fixed while items are in flight; unenforced
    assign cq_out      = cq_out_bits;
    assign cell_op     = cq_out.op;
    assign cell_col    = cq_out.col;
    assign cell_row    = cq_out.row;
    assign glyph_code  = cq_out.glyph;
    assign last_of_run = cq_out.last;
    assign ink_color   = fore_reg;
    assign paper_color = back_reg;

endmodule

@@ hdl/tcce_fifo.sv @@
// Small register queue used between the engine stages and at the output.
// Depends on nothing; DEPTH must be at least 2.
module tcce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the payload slot
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/tcce_front.sv @@
// Front end: takes input items and sorts them into cursor actions.
// Depends on tcce_pkg.
module tcce_front
    import tcce_pkg::*;
(
    input  logic       push,
    output logic       full,
    input  logic       req_type,
    input  logic [7:0] char_code,
    output logic       q_push,
    output item_t      q_data,
    input  logic       q_full
);

    assign full   = q_full;
    assign q_push = push && !q_full;

    // Classify the request
    always_comb
    begin
        q_data.code = char_code;
        if (req_type == REQ_CLEAR)
        begin
            q_data.kind = KIND_CLEAR;
        end
        else
        begin
            case (char_code)
                CHAR_NL:  q_data.kind = KIND_NL;
                CHAR_BS:  q_data.kind = KIND_BS;
                CHAR_CR:  q_data.kind = KIND_CR;
                CHAR_TAB: q_data.kind = KIND_TAB;
                default:  q_data.kind = KIND_GLYPH;
            endcase
        end
    end

endmodule

@@ hdl/tcce_back.sv @@
// Back end: holds the cursor, carries out each action and emits cell commands.
// Depends on tcce_pkg and the assertion macro header.
`include "text_console_cursor_engine_core_macros.svh"

module tcce_back
    import tcce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  geom_t geom,
    input  logic  item_empty,
    input  item_t item_data,
    output logic  item_pop,
    input  logic  out_full,
    output logic  cmd_push,
    output cmd_t  cmd_data
);

    logic [7:0] cursor_col_reg, cursor_col_next;
    logic [6:0] cursor_row_reg, cursor_row_next;
    logic       pend_scroll_reg, pend_scroll_next;

    logic [8:0] new_col;
    logic [7:0] new_row;
    logic       has_first;
    logic       need_scroll;
    cmd_t       first_cmd;
    cmd_t       scroll_cmd;

    assign item_pop = !item_empty && !pend_scroll_reg && !out_full;

    assign scroll_cmd = '{op: OP_SCROLL, col: '0, row: '0, glyph: '0, last: 1'b1};

    // Work out the first command and the new cursor for the head item
    always_comb
    begin
        new_col   = {1'b0, cursor_col_reg};
        new_row   = {1'b0, cursor_row_reg};
        has_first = 1'b0;
        first_cmd = '{op: OP_DRAW, col: cursor_col_reg, row: cursor_row_reg,
                      glyph: '0, last: 1'b0};
        case (item_data.kind)
            KIND_NL:
            begin
                new_col = '0;
                new_row = new_row + 1'b1;
            end
            KIND_BS:
            begin
                if (cursor_col_reg != '0)
                begin
                    new_col       = new_col - 1'b1;
                    has_first     = 1'b1;
                    first_cmd.op  = OP_ERASE;
                    first_cmd.col = new_col[7:0];
                end
            end
            KIND_CR:
            begin
                new_col = '0;
            end
            KIND_TAB:
            begin
                new_col = (new_col + TAB_STEP) & TAB_MASK;
            end
            KIND_CLEAR:
            begin
                has_first     = 1'b1;
                first_cmd.op  = OP_CLEAR;
                first_cmd.col = '0;
                first_cmd.row = '0;
            end
            default:
            begin
                has_first       = 1'b1;
                first_cmd.glyph = item_data.code;
                new_col         = new_col + 1'b1;
            end
        endcase

        // Wrap past the right edge
        if (new_col >= geom.w)
        begin
            new_col = '0;
            new_row = new_row + 1'b1;
        end

        // Scroll past the bottom row; a clear never scrolls
        need_scroll = (item_data.kind != KIND_CLEAR) && (new_row >= geom.h);
        if (need_scroll)
        begin
            new_row = geom.h - 1'b1;
        end
        first_cmd.last = !need_scroll;
    end

    // Issue commands and update the cursor
    always_comb
    begin
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        pend_scroll_next = pend_scroll_reg;
        cmd_push         = 1'b0;
        cmd_data         = first_cmd;
        if (pend_scroll_reg)
        begin
            cmd_data = scroll_cmd;
            if (!out_full)
            begin
                cmd_push         = 1'b1;
                pend_scroll_next = 1'b0;
            end
        end
        else if (item_pop)
        begin
            if (item_data.kind == KIND_CLEAR)
            begin
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            else
            begin
                cursor_col_next = new_col[7:0];
                cursor_row_next = new_row[6:0];
            end
            if (has_first)
            begin
                cmd_push         = 1'b1;
                pend_scroll_next = need_scroll;
            end
            else if (need_scroll)
            begin
                cmd_push = 1'b1;
                cmd_data = scroll_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            pend_scroll_reg <= 1'b0;
        end
        else
        begin
            cursor_col_reg  <= cursor_col_next;
            cursor_row_reg  <= cursor_row_next;
            pend_scroll_reg <= pend_scroll_next;
        end
    end

    `TCCE_ASSERT_IMPL(a_no_pop_while_pending, pend_scroll_reg, !item_pop,
        "item taken while a scroll is still pending")
    `TCCE_ASSERT_IMPL(a_push_has_room, cmd_push, !out_full,
        "command pushed into a full output queue")
    `TCCE_ASSERT_IMPL(a_pending_is_scroll, pend_scroll_reg && cmd_push,
        cmd_data.op == OP_SCROLL && cmd_data.last,
        "pending command is not a final scroll")
    `TCCE_ASSERT_NEXT(a_cursor_on_screen, item_pop,
        {1'b0, cursor_col_reg} < geom.w && {1'b0, cursor_row_reg} < geom.h,
        "cursor left outside the screen after an item")

endmodule
